// File: src/wsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wsd_pkg;

	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;
	localparam logic [2:0] EXT_BYTES_16 = 3'd1;
	localparam logic [2:0] EXT_BYTES_64 = 3'd7;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	typedef enum logic [5:0] {
		PH_HDR0 = 6'b000001,
		PH_HDR1 = 6'b000010,
		PH_EXT  = 6'b000100,
		PH_KEY  = 6'b001000,
		PH_DATA = 6'b010000,
		PH_DROP = 6'b100000
	} phase_t;

	typedef struct packed {
		kind_t       kind;
		logic        fin_flag;
		logic [2:0]  reserved_bits;
		logic [3:0]  frame_opcode;
		logic [63:0] payload_size;
		logic [7:0]  payload_byte;
		logic        last;
	} result_t;

endpackage
`default_nettype wire

// File: src/wsd_parser.sv
`timescale 1ns / 1ps
`default_nettype none
module wsd_parser
	import wsd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] data_byte,
	input  wire logic       frame_start,
	output logic            res_valid,
	output result_t         res
);

	phase_t      phase_q, phase_d, cur_phase;
	logic [7:0]  flags_q, flags_d;
	logic [2:0]  ext_q, ext_d;
	logic [63:0] len_q, len_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  keycnt_q, keycnt_d;
	logic [63:0] cnt_q, cnt_d;
	logic        masked_q, masked_d;
	logic [63:0] cnt_inc;
	logic [7:0]  key_sel;
	logic        len_done;
	logic        done_masked;
	logic [6:0]  code;

	assign cur_phase = frame_start ? PH_HDR0 : phase_q;
	assign code      = data_byte[6:0];
	assign cnt_inc   = cnt_q + 64'd1;

	always_comb begin
		unique case (cnt_q[1:0])
			2'd0:    key_sel = key_q[31:24];
			2'd1:    key_sel = key_q[23:16];
			2'd2:    key_sel = key_q[15:8];
			default: key_sel = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d     = cur_phase;
		flags_d     = flags_q;
		ext_d       = ext_q;
		len_d       = len_q;
		key_d       = key_q;
		keycnt_d    = keycnt_q;
		cnt_d       = cnt_q;
		masked_d    = masked_q;
		len_done    = 1'b0;
		done_masked = masked_q;
		res_valid   = 1'b0;
		res.kind    = KIND_HEADER;
		res.payload_byte = 8'd0;
		res.last    = 1'b0;
		unique case (cur_phase)
			PH_HDR0: begin
				flags_d = data_byte;
				len_d   = 64'd0;
				cnt_d   = 64'd0;
				ext_d   = 3'd0;
				phase_d = PH_HDR1;
			end
			PH_HDR1: begin
				masked_d    = data_byte[7];
				done_masked = data_byte[7];
				if (code == LEN_CODE_16) begin
					ext_d   = EXT_BYTES_16;
					len_d   = 64'd0;
					phase_d = PH_EXT;
				end else if (code == LEN_CODE_64) begin
					ext_d   = EXT_BYTES_64;
					len_d   = 64'd0;
					phase_d = PH_EXT;
				end else begin
					len_d    = {57'd0, code};
					len_done = 1'b1;
				end
			end
			PH_EXT: begin
				len_d = {len_q[55:0], data_byte};
				if (ext_q == 3'd0) begin
					len_done = 1'b1;
				end else begin
					ext_d = ext_q - 3'd1;
				end
			end
			PH_KEY: begin
				key_d = {key_q[23:0], data_byte};
				if (keycnt_q == 2'd3) begin
					keycnt_d  = 2'd0;
					cnt_d     = 64'd0;
					res_valid = 1'b1;
					res.kind  = KIND_HEADER;
					res.last  = (len_q == 64'd0);
					phase_d   = (len_q == 64'd0) ? PH_HDR0 : PH_DATA;
				end else begin
					keycnt_d = keycnt_q + 2'd1;
				end
			end
			PH_DATA: begin
				cnt_d            = cnt_inc;
				res_valid        = 1'b1;
				res.kind         = KIND_DATA;
				res.payload_byte = data_byte ^ key_sel;
				res.last         = (cnt_inc == len_q);
				if (cnt_inc == len_q) begin
					phase_d = PH_HDR0;
				end
			end
			PH_DROP: begin
				phase_d = PH_DROP;
			end
			default: begin
				phase_d = PH_HDR0;
			end
		endcase
		// length known: either raise the unmasked error or collect the key
		if (len_done) begin
			if (!done_masked) begin
				phase_d   = PH_DROP;
				res_valid = 1'b1;
				res.kind  = KIND_ERROR;
				res.last  = 1'b1;
			end else begin
				phase_d  = PH_KEY;
				keycnt_d = 2'd0;
				key_d    = 32'd0;
			end
		end
		res.fin_flag      = flags_d[7];
		res.reserved_bits = flags_d[6:4];
		res.frame_opcode  = flags_d[3:0];
		res.payload_size  = len_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			flags_q  <= 8'd0;
			ext_q    <= 3'd0;
			len_q    <= 64'd0;
			key_q    <= 32'd0;
			keycnt_q <= 2'd0;
			cnt_q    <= 64'd0;
			masked_q <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			flags_q  <= flags_d;
			ext_q    <= ext_d;
			len_q    <= len_d;
			key_q    <= key_d;
			keycnt_q <= keycnt_d;
			cnt_q    <= cnt_d;
			masked_q <= masked_d;
		end
	end

endmodule
`default_nettype wire

// File: src/websocket_frame_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// Client-to-server WebSocket frame deframer and unmasker. Takes one frame byte
// per clock on the input channel (frame_start forces a new header) and gives
// at most one result per byte: a header result after the fourth mask key
// byte, one unmasked payload byte per payload byte with last on the final
// one, or an error result when the frame is not masked, after which bytes
// are dropped until the next frame_start. Each byte is parsed in the cycle it
// is transferred and its result appears in the output register on the next
// cycle; input ready stays high unless that register holds a result that
// out_ready does not take, so the sustained rate is one byte per clock.
module websocket_frame_deframer
	import wsd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        frame_start,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic             fin_flag,
	output logic [2:0]       reserved_bits,
	output logic [3:0]       frame_opcode,
	output logic [63:0]      payload_size,
	output logic [7:0]       payload_byte,
	output logic             last
);

	logic    step;
	logic    res_valid;
	result_t res;
	result_t res_q;
	logic    out_valid_q;

	assign in_ready = !out_valid_q || out_ready;
	assign step     = in_valid && in_ready;

	wsd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.data_byte   (data_byte),
		.frame_start (frame_start),
		.res_valid   (res_valid),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the result until transfer
	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = res_q.kind;
	assign fin_flag       = res_q.fin_flag;
	assign reserved_bits  = res_q.reserved_bits;
	assign frame_opcode   = res_q.frame_opcode;
	assign payload_size   = res_q.payload_size;
	assign payload_byte   = res_q.payload_byte;
	assign last           = res_q.last;

`ifndef SYNTHESIS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ERROR |-> last)
		else $error("error result without last");

	a_byte_only_on_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_DATA |-> payload_byte == 8'd0)
		else $error("payload byte set on non-data result");

	a_result_follows_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(step) && $past(out_valid) && $past(out_ready) |-> !out_valid)
		else $error("result repeated after transfer");
`endif

endmodule
`default_nettype wire
